/* rtl/core/csvft_pkg.sv */
// Shared constants and types for the CSV field tokenizer.
package csvft_pkg;

   localparam int LINE_COUNT_BITS_DEFAULT = 32;

   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_FIELD  = 2'd1;
   localparam logic [1:0] KIND_RECORD = 2'd2;

   localparam logic [2:0] MODE_REC_START   = 3'd0;
   localparam logic [2:0] MODE_FIELD_START = 3'd1;
   localparam logic [2:0] MODE_UNQUOTED    = 3'd2;
   localparam logic [2:0] MODE_QUOTED      = 3'd3;
   localparam logic [2:0] MODE_QUOTE_SEEN  = 3'd4;
   localparam logic [2:0] MODE_AFTER_CR    = 3'd5;

   localparam logic [15:0] FIELD_MAX = 16'hFFFF;

   typedef struct packed {
      logic       emit;
      logic [1:0] kind;
      logic [7:0] byte_out;
      logic [2:0] mode_next;
   } step_type;

endpackage

/* rtl/core/csvft_req_if.sv */
// Input channel: one byte or end-of-input marker per word.
interface csvft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_input;

   modport source (output valid, output byte_in, output end_of_input, input ready);
   modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

/* rtl/core/csvft_rsp_if.sv */
// Result channel: content byte or field/record end mark per word.
interface csvft_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   logic [1:0]  kind;
   logic [15:0] field_index;
   logic [31:0] line_count;

   modport source (output valid, output byte_out, output kind, output field_index,
                   output line_count, input ready);
   modport sink   (input valid, input byte_out, input kind, input field_index,
                   input line_count, output ready);
endinterface

/* rtl/core/csvft_step.sv */
// Parser next-state and result logic for one input word.
module csvft_step #(
   parameter int LINE_BITS = csvft_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  logic [2:0]           mode,
   input  logic [LINE_BITS-1:0] line_cnt,
   input  logic [15:0]          field_cnt,
   input  logic [7:0]           separator,
   input  logic [7:0]           byte_in,
   input  logic                 end_of_input,
   output csvft_pkg::step_type  step,
   output logic [LINE_BITS-1:0] line_next,
   output logic [15:0]          field_next
);

   logic is_sep, is_cr, is_lf, is_quote;
   logic do_first, do_rest, do_end, line_inc;
   logic [2:0] end_mode;

   assign is_sep   = (byte_in == separator);
   assign is_cr    = (byte_in == csvft_pkg::CH_CR);
   assign is_lf    = (byte_in == csvft_pkg::CH_LF);
   assign is_quote = (byte_in == csvft_pkg::CH_QUOTE);

   always_comb begin
      step.emit      = 1'b0;
      step.kind      = csvft_pkg::KIND_BYTE;
      step.byte_out  = 8'd0;
      step.mode_next = mode;
      field_next     = field_cnt;
      line_inc       = 1'b0;
      do_first       = 1'b0;
      do_rest        = 1'b0;
      do_end         = 1'b0;
      end_mode       = csvft_pkg::MODE_REC_START;

      case (mode)
         csvft_pkg::MODE_AFTER_CR: begin
            // swallow the LF of a CR LF pair
            if (end_of_input || is_lf) begin
               step.mode_next = csvft_pkg::MODE_REC_START;
            end else begin
               do_first = 1'b1;
            end
         end
         csvft_pkg::MODE_FIELD_START: begin
            if (end_of_input) do_end = 1'b1;
            else do_first = 1'b1;
         end
         csvft_pkg::MODE_UNQUOTED: begin
            if (end_of_input) do_end = 1'b1;
            else do_rest = 1'b1;
         end
         csvft_pkg::MODE_QUOTED: begin
            if (end_of_input) begin
               do_end = 1'b1;
            end else if (is_quote) begin
               step.mode_next = csvft_pkg::MODE_QUOTE_SEEN;
            end else begin
               line_inc       = is_lf;
               step.emit      = 1'b1;
               step.byte_out  = byte_in;
               step.mode_next = csvft_pkg::MODE_QUOTED;
            end
         end
         csvft_pkg::MODE_QUOTE_SEEN: begin
            if (end_of_input) begin
               do_end = 1'b1;
            end else if (is_quote) begin
               step.emit      = 1'b1;
               step.byte_out  = csvft_pkg::CH_QUOTE;
               step.mode_next = csvft_pkg::MODE_QUOTED;
            end else begin
               do_rest = 1'b1;
            end
         end
         default: begin
            if (end_of_input) step.mode_next = csvft_pkg::MODE_REC_START;
            else do_first = 1'b1;
         end
      endcase

      if (do_first) begin
         if (is_quote) step.mode_next = csvft_pkg::MODE_QUOTED;
         else do_rest = 1'b1;
      end

      if (do_rest) begin
         if (is_sep) begin
            step.emit      = 1'b1;
            step.kind      = csvft_pkg::KIND_FIELD;
            step.mode_next = csvft_pkg::MODE_FIELD_START;
            if (field_cnt != csvft_pkg::FIELD_MAX) field_next = field_cnt + 16'd1;
         end else if (is_cr) begin
            do_end   = 1'b1;
            end_mode = csvft_pkg::MODE_AFTER_CR;
         end else if (is_lf) begin
            do_end = 1'b1;
         end else begin
            step.emit      = 1'b1;
            step.byte_out  = byte_in;
            step.mode_next = csvft_pkg::MODE_UNQUOTED;
         end
      end

      if (do_end) begin
         line_inc       = 1'b1;
         step.emit      = 1'b1;
         step.kind      = csvft_pkg::KIND_RECORD;
         step.mode_next = end_mode;
         field_next     = 16'd0;
      end

      line_next = line_inc ? line_cnt + LINE_BITS'(1) : line_cnt;
   end

endmodule

/* rtl/core/csv_field_tokenizer_core.sv */
// Top level of the CSV field tokenizer: state, separator and result registers.
// A result is registered and appears on rsp_chan in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the combinational parser update feeds the
//    result register, and req_chan.ready stays high while that register is empty or taken.
// Reset (synchronous): mode returns to record start, line and field counters clear,
//    separator returns to comma and no result is pending.
module csv_field_tokenizer_core #(
   parameter int LINE_COUNT_BITS = csvft_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   csvft_req_if.sink   req_chan,
   csvft_rsp_if.source rsp_chan,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic [2:0]                 mode_ff, mode_in;
   logic [LINE_COUNT_BITS-1:0] line_ff, line_in;
   logic [15:0]                field_ff, field_in;
   logic [7:0]                 sep_ff, sep_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_byte_ff;
   logic [1:0]                 rsp_kind_ff;
   logic [15:0]                rsp_field_ff;
   logic [31:0]                rsp_line_ff;
   logic                       accept;
   csvft_pkg::step_type        step;
   logic [LINE_COUNT_BITS-1:0] line_next;
   logic [15:0]                field_next;

   csvft_step #(.LINE_BITS(LINE_COUNT_BITS)) u_step (
      .mode         (mode_ff),
      .line_cnt     (line_ff),
      .field_cnt    (field_ff),
      .separator    (sep_ff),
      .byte_in      (req_chan.byte_in),
      .end_of_input (req_chan.end_of_input),
      .step         (step),
      .line_next    (line_next),
      .field_next   (field_next)
   );

   // take a new word whenever the result register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      mode_in  = accept ? step.mode_next : mode_ff;
      line_in  = accept ? line_next : line_ff;
      field_in = accept ? field_next : field_ff;
      sep_in   = csr_write_enable ? csr_write_data : sep_ff;
      if (accept) rsp_valid_in = step.emit;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= csvft_pkg::MODE_REC_START;
         line_ff      <= '0;
         field_ff     <= 16'd0;
         sep_ff       <= csvft_pkg::CH_COMMA;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         field_ff     <= field_in;
         sep_ff       <= sep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff  <= step.byte_out;
         rsp_kind_ff  <= step.kind;
         rsp_field_ff <= field_ff;
         rsp_line_ff  <= 32'(line_next);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.byte_out    = rsp_byte_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.field_index = rsp_field_ff;
   assign rsp_chan.line_count  = rsp_line_ff;

`ifndef SYNTHESIS
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff == csvft_pkg::KIND_BYTE ||
                        rsp_kind_ff == csvft_pkg::KIND_FIELD ||
                        rsp_kind_ff == csvft_pkg::KIND_RECORD))
      else $error("result kind out of range");

   a_mark_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != csvft_pkg::KIND_BYTE) |-> (rsp_byte_ff == 8'd0))
      else $error("end mark carries a nonzero byte");

   a_record_clears_field: assert property (@(posedge clock) disable iff (reset)
      (accept && step.emit && step.kind == csvft_pkg::KIND_RECORD) |=> (field_ff == 16'd0))
      else $error("field index not cleared at record end");

   a_line_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(line_ff))
      else $error("line counter moved without an accepted word");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the CSV field tokenizer core: directed and random CSV streams checked token by token.
module tb_top;

   localparam int IDLE_LIMIT    = 4000;
   localparam int PHASE_ITEMS   = 160;
   localparam int LONG_HOLD     = 400;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_input;
   } char_word_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [1:0]  kind;
      logic [15:0] field_index;
      logic [31:0] line_count;
   } token_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   csvft_req_if req_if ();
   csvft_rsp_if rsp_if ();

   csv_field_tokenizer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   char_word_type char_q[$];
   token_type     token_q[$];

   int items_queued    = 0;
   int items_accepted  = 0;
   int mismatches      = 0;
   int idle_cycles     = 0;
   int burst_left      = 1;
   int gap_left        = 0;
   int hold_left       = 0;
   int window_left     = 0;
   int stall_kind      = 0;
   int ready_tick      = 0;
   bit long_hold_done  = 1'b0;

   logic [7:0]    phase_sep;
   char_word_type cur_word;
   token_type     seen_token;
   token_type     want_token;

   // mirror of the tokenizer state
   logic [2:0]  tk_mode;
   logic [31:0] tk_lines;
   logic [15:0] tk_field;
   logic [7:0]  tk_sep;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic push_token(input logic [1:0] tok_kind, input logic [7:0] data);
      token_type t;
      t.byte_out    = (tok_kind == csvft_pkg::KIND_BYTE) ? data : 8'd0;
      t.kind        = tok_kind;
      t.field_index = tk_field;
      t.line_count  = tk_lines;
      token_q.push_back(t);
      if (tok_kind == csvft_pkg::KIND_FIELD) begin
         if (tk_field != csvft_pkg::FIELD_MAX) tk_field = tk_field + 16'd1;
         tk_mode = csvft_pkg::MODE_FIELD_START;
      end else if (tok_kind == csvft_pkg::KIND_RECORD) begin
         tk_field = 16'd0;
      end
   endtask

   task automatic close_record(input logic [2:0] next_mode);
      tk_lines = tk_lines + 32'd1;
      tk_mode  = next_mode;
      push_token(csvft_pkg::KIND_RECORD, 8'd0);
   endtask

   // byte outside quotes: plain field or tail after a closing quote
   task automatic plain_char(input logic [7:0] c);
      if (c == tk_sep) push_token(csvft_pkg::KIND_FIELD, 8'd0);
      else if (c == csvft_pkg::CH_CR) close_record(csvft_pkg::MODE_AFTER_CR);
      else if (c == csvft_pkg::CH_LF) close_record(csvft_pkg::MODE_REC_START);
      else begin
         tk_mode = csvft_pkg::MODE_UNQUOTED;
         push_token(csvft_pkg::KIND_BYTE, c);
      end
   endtask

   task automatic first_char(input logic [7:0] c);
      if (c == csvft_pkg::CH_QUOTE) tk_mode = csvft_pkg::MODE_QUOTED;
      else plain_char(c);
   endtask

   task automatic tokenize_char(input char_word_type w);
      logic [7:0] c;
      c = w.byte_in;
      case (tk_mode)
         csvft_pkg::MODE_AFTER_CR: begin
            // drop the LF of a CR LF pair
            if (w.end_of_input || c == csvft_pkg::CH_LF) tk_mode = csvft_pkg::MODE_REC_START;
            else first_char(c);
         end
         csvft_pkg::MODE_FIELD_START, csvft_pkg::MODE_UNQUOTED, csvft_pkg::MODE_QUOTED,
         csvft_pkg::MODE_QUOTE_SEEN: begin
            if (w.end_of_input) close_record(csvft_pkg::MODE_REC_START);
            else if (tk_mode == csvft_pkg::MODE_FIELD_START) first_char(c);
            else if (tk_mode == csvft_pkg::MODE_UNQUOTED) plain_char(c);
            else if (tk_mode == csvft_pkg::MODE_QUOTED) begin
               if (c == csvft_pkg::CH_QUOTE) tk_mode = csvft_pkg::MODE_QUOTE_SEEN;
               else begin
                  if (c == csvft_pkg::CH_LF) tk_lines = tk_lines + 32'd1;
                  push_token(csvft_pkg::KIND_BYTE, c);
               end
            end else if (c == csvft_pkg::CH_QUOTE) begin
               tk_mode = csvft_pkg::MODE_QUOTED;
               push_token(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE);
            end else plain_char(c);
         end
         default: begin
            if (w.end_of_input) tk_mode = csvft_pkg::MODE_REC_START;
            else first_char(c);
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] plain_byte(input bit no_quote);
      logic [7:0] b;
      do b = rand_byte();
      while (b == phase_sep || b == csvft_pkg::CH_CR || b == csvft_pkg::CH_LF ||
             (no_quote && b == csvft_pkg::CH_QUOTE));
      return b;
   endfunction

   task automatic queue_word(input logic [7:0] b, input logic eoi);
      char_word_type w;
      w.byte_in      = b;
      w.end_of_input = eoi;
      char_q.push_back(w);
      items_queued++;
   endtask

   task automatic queue_record();
      int nfields;
      int len;
      int f;
      int k;
      nfields = $urandom_range(1, 5);
      for (f = 0; f < nfields; f++) begin
         if (f != 0) queue_word(phase_sep, 1'b0);
         case ($urandom_range(0, 3))
            0: ;  // leave the field empty
            1, 2: begin
               len = $urandom_range(1, 6);
               for (k = 0; k < len; k++) queue_word(plain_byte(k == 0), 1'b0);
            end
            default: begin
               queue_word(csvft_pkg::CH_QUOTE, 1'b0);
               len = $urandom_range(0, 6);
               for (k = 0; k < len; k++) begin
                  case ($urandom_range(0, 9))
                     0, 1: begin
                        queue_word(csvft_pkg::CH_QUOTE, 1'b0);
                        queue_word(csvft_pkg::CH_QUOTE, 1'b0);
                     end
                     2: queue_word(csvft_pkg::CH_CR, 1'b0);
                     3: queue_word(csvft_pkg::CH_LF, 1'b0);
                     4: queue_word(phase_sep, 1'b0);
                     default: queue_word(plain_byte(1'b1), 1'b0);
                  endcase
               end
               queue_word(csvft_pkg::CH_QUOTE, 1'b0);
               if ($urandom_range(0, 3) == 0) queue_word(plain_byte(1'b0), 1'b0);
            end
         endcase
      end
      case ($urandom_range(0, 3))
         0: queue_word(csvft_pkg::CH_CR, 1'b0);
         1: queue_word(csvft_pkg::CH_LF, 1'b0);
         2: begin
            queue_word(csvft_pkg::CH_CR, 1'b0);
            queue_word(csvft_pkg::CH_LF, 1'b0);
         end
         default: queue_word(rand_byte(), 1'b1);
      endcase
   endtask

   task automatic queue_noise();
      int n;
      int k;
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0: queue_word(rand_byte(), 1'b1);
            1: queue_word(phase_sep, 1'b0);
            2: queue_word(csvft_pkg::CH_QUOTE, 1'b0);
            3: queue_word(csvft_pkg::CH_CR, 1'b0);
            4: queue_word(csvft_pkg::CH_LF, 1'b0);
            default: queue_word(rand_byte(), 1'b0);
         endcase
      end
   endtask

   task automatic queue_random_items(input int target);
      int start_count;
      start_count = items_queued;
      while (items_queued - start_count < target) begin
         if ($urandom_range(0, 9) < 8) queue_record();
         else queue_noise();
      end
   endtask

   task automatic drain();
      while (items_accepted != items_queued || token_q.size() != 0) @(posedge clock);
      // a word that makes no token may still sit in the core
      repeat (3) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tk_sep    = v;
      phase_sep = v;
   endtask

   initial begin
      int p;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = 8'd0;
      req_if.valid        = 1'b0;
      req_if.byte_in      = 8'd0;
      req_if.end_of_input = 1'b0;
      rsp_if.ready        = 1'b0;
      tk_mode             = csvft_pkg::MODE_REC_START;
      tk_lines            = 32'd0;
      tk_field            = 16'd0;
      tk_sep              = csvft_pkg::CH_COMMA;
      phase_sep           = csvft_pkg::CH_COMMA;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // opening sequence on the reset separator
      queue_word(rand_byte(), 1'b1);                     // end of input at record start
      queue_word(8'h00, 1'b0); queue_word(8'hFF, 1'b0);  // byte extremes
      queue_word(csvft_pkg::CH_COMMA, 1'b0);
      queue_word(rand_byte(), 1'b1);                     // empty field after a separator
      queue_word(csvft_pkg::CH_QUOTE, 1'b0);             // quoted: separator, CR, LF kept
      queue_word(csvft_pkg::CH_COMMA, 1'b0);
      queue_word(csvft_pkg::CH_CR, 1'b0);
      queue_word(csvft_pkg::CH_LF, 1'b0);
      queue_word(csvft_pkg::CH_QUOTE, 1'b0);             // doubled quote
      queue_word(csvft_pkg::CH_QUOTE, 1'b0);
      queue_word(csvft_pkg::CH_QUOTE, 1'b0);             // closing quote
      queue_word(8'h7A, 1'b0);                           // tail, quote mid-field
      queue_word(csvft_pkg::CH_QUOTE, 1'b0);
      queue_word(csvft_pkg::CH_CR, 1'b0);                // CR LF
      queue_word(csvft_pkg::CH_LF, 1'b0);
      queue_word(8'h71, 1'b0); queue_word(csvft_pkg::CH_CR, 1'b0);  // lone CR then a byte
      queue_word(8'h72, 1'b0); queue_word(csvft_pkg::CH_LF, 1'b0);
      queue_word(csvft_pkg::CH_QUOTE, 1'b0);             // unclosed quoted field
      queue_word(rand_byte(), 1'b1);
      queue_word(csvft_pkg::CH_CR, 1'b0);                // end of input after CR
      queue_word(rand_byte(), 1'b1);
      queue_word(csvft_pkg::CH_QUOTE, 1'b0); queue_word(csvft_pkg::CH_QUOTE, 1'b0);
      queue_word(rand_byte(), 1'b1);                     // end of input after closing quote
      drain();

      for (p = 0; p < 10; p++) begin
         case (p)
            0: write_separator(csvft_pkg::CH_COMMA);
            1: write_separator(8'h00);
            2: write_separator(8'hFF);
            3: write_separator(csvft_pkg::CH_QUOTE);
            4: write_separator(csvft_pkg::CH_CR);
            5: write_separator(csvft_pkg::CH_LF);
            6: write_separator(8'h3B);
            7: write_separator(8'h09);
            default: write_separator(rand_byte());
         endcase
         queue_random_items(PHASE_ITEMS);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && token_q.size() == 0) $display("csv_field_tokenizer_core: match");
      else $display("csv_field_tokenizer_core: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.byte_in      <= 8'd0;
         req_if.end_of_input <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            tokenize_char(cur_word);
            items_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (char_q.size() != 0) begin
               cur_word = char_q.pop_front();
               req_if.valid        <= 1'b1;
               req_if.byte_in      <= cur_word.byte_in;
               req_if.end_of_input <= cur_word.end_of_input;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3: gap_left = 0;
                     4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                     8: gap_left = $urandom_range(5, 15);
                     default: gap_left = $urandom_range(20, 40);
                  endcase
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left   = 0;
         window_left = 0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!long_hold_done && char_q.size() > 100) begin
         // hold off long enough for the core to back up into the sender
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_if.ready  <= 1'b0;
      end else begin
         if (window_left == 0) begin
            window_left = $urandom_range(16, 96);
            stall_kind  = $urandom_range(0, 3);
         end
         window_left--;
         ready_tick++;
         case (stall_kind)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= (ready_tick % 4 != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_token.byte_out    = rsp_if.byte_out;
         seen_token.kind        = rsp_if.kind;
         seen_token.field_index = rsp_if.field_index;
         seen_token.line_count  = rsp_if.line_count;
         if (token_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token: kind %0d byte %02h field %0d line %0d",
                        seen_token.kind, seen_token.byte_out, seen_token.field_index,
                        seen_token.line_count);
         end else begin
            want_token = token_q.pop_front();
            if (seen_token !== want_token) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("token %0d: kind %0d/%0d byte %02h/%02h field %0d/%0d line %0d/%0d",
                           mismatches, want_token.kind, seen_token.kind,
                           want_token.byte_out, seen_token.byte_out,
                           want_token.field_index, seen_token.field_index,
                           want_token.line_count, seen_token.line_count);
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("csv_field_tokenizer_core: mismatch");
            $finish;
         end
      end
   end

endmodule
